@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define DRF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define DRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define DRF_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DRF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/drf_pkg.sv @@
// types, codes and reset constants of the delta report filter
// no dependencies
`default_nettype none

package drf_pkg;

	// item modes
	localparam logic [1:0] MODE_TICK   = 2'd0;
	localparam logic [1:0] MODE_SUB    = 2'd1;
	localparam logic [1:0] MODE_CANCEL = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_CRIT_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRIT_DELTA     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_DELTA   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CRIT_MAX_AGE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_BATTERY    = 3'd6;

	// reset values
	localparam logic [7:0]  RST_CRIT_THRESHOLD = 8'd35;
	localparam logic [7:0]  RST_CRIT_DELTA     = 8'd1;
	localparam logic [7:0]  RST_NORMAL_DELTA   = 8'd2;
	localparam logic [15:0] RST_MAX_AGE_LIMIT  = 16'd60;
	localparam logic [15:0] RST_CRIT_MAX_AGE   = 16'd5;
	localparam logic [7:0]  RST_TICK_PERIOD    = 8'd5;
	localparam logic [6:0]  RST_LOW_BATTERY    = 7'd30;
	localparam logic [7:0]  RST_LAST_READING   = 8'd10;

	localparam logic [15:0] AGE_STEP = 16'd10;
	localparam logic [15:0] AGE_MAX  = 16'hFFFF;

	typedef enum logic [1:0] {
		LVL_NONE,
		LVL_NORMAL,
		LVL_CRITICAL
	} level_t;

	typedef struct packed {
		logic [7:0]  crit_threshold;
		logic [7:0]  crit_delta;
		logic [7:0]  normal_delta;
		logic [15:0] max_age_limit;
		logic [15:0] crit_max_age;
		logic [7:0]  tick_period;
		logic [6:0]  low_battery;
	} cfg_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] reading;
		logic [6:0] battery_level;
		logic       critical_only;
	} item_t;

	typedef struct packed {
		logic        send;
		logic        is_critical;
		logic [7:0]  reported_reading;
		logic [15:0] max_age;
	} result_t;

	typedef struct packed {
		logic        subscribed;
		logic        crit_only;
		logic [7:0]  last_reading;
		logic [15:0] age;
		logic [15:0] cur_max_age;
	} state_t;

endpackage

`default_nettype wire

@@ hw/rtl/drf_cfg_regs.sv @@
// configuration register file of the delta report filter
// depends on drf_pkg
`default_nettype none

module drf_cfg_regs import drf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crit_threshold <= RST_CRIT_THRESHOLD;
			cfg_q.crit_delta     <= RST_CRIT_DELTA;
			cfg_q.normal_delta   <= RST_NORMAL_DELTA;
			cfg_q.max_age_limit  <= RST_MAX_AGE_LIMIT;
			cfg_q.crit_max_age   <= RST_CRIT_MAX_AGE;
			cfg_q.tick_period    <= RST_TICK_PERIOD;
			cfg_q.low_battery    <= RST_LOW_BATTERY;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CRIT_THRESHOLD: cfg_q.crit_threshold <= cfg_wdata[7:0];
				REG_CRIT_DELTA:     cfg_q.crit_delta     <= cfg_wdata[7:0];
				REG_NORMAL_DELTA:   cfg_q.normal_delta   <= cfg_wdata[7:0];
				REG_MAX_AGE_LIMIT:  cfg_q.max_age_limit  <= cfg_wdata;
				REG_CRIT_MAX_AGE:   cfg_q.crit_max_age   <= cfg_wdata;
				REG_TICK_PERIOD:    cfg_q.tick_period    <= cfg_wdata[7:0];
				REG_LOW_BATTERY:    cfg_q.low_battery    <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/drf_decide.sv @@
// report decision for one item: next subscription state and the result
// depends on drf_pkg
`default_nettype none

module drf_decide import drf_pkg::*; (
	input  cfg_t    cfg,
	input  state_t  st,
	input  item_t   item,
	output state_t  st_next,
	output result_t res
);

	logic [16:0] age_sum;
	logic [15:0] age_sat;
	logic [16:0] expire_sum;
	logic        expired;
	logic [8:0]  delta;
	logic [8:0]  delta_abs;
	logic [7:0]  diff;
	logic        reading_crit;
	logic        sub_crit;
	logic        active;
	logic [16:0] grow_base;
	logic [15:0] grown_age;
	level_t      level;

	always_comb begin
		age_sum    = {1'b0, st.age} + {9'd0, cfg.tick_period};
		age_sat    = age_sum[16] ? AGE_MAX : age_sum[15:0];
		expire_sum = {1'b0, age_sat} + {9'd0, cfg.tick_period};
		expired    = expire_sum >= {1'b0, st.cur_max_age};

		delta     = {item.reading[7], item.reading} - {st.last_reading[7], st.last_reading};
		delta_abs = delta[8] ? (9'd0 - delta) : delta;
		diff      = delta_abs[7:0];

		reading_crit = $signed(item.reading) >= $signed(cfg.crit_threshold);
		sub_crit     = $signed(item.reading) > $signed(cfg.crit_threshold);
		active       = st.subscribed && (item.battery_level != 7'd0);

		// normal report restarts growth from the step after a critical period
		grow_base = (st.cur_max_age == cfg.crit_max_age) ? {1'b0, AGE_STEP}
			: ({1'b0, st.cur_max_age} + {1'b0, AGE_STEP});
		grown_age = (grow_base > {1'b0, cfg.max_age_limit}) ? cfg.max_age_limit
			: grow_base[15:0];

		if (expired) begin
			if (reading_crit)
				level = LVL_CRITICAL;
			else if (!st.crit_only)
				level = LVL_NORMAL;
			else
				level = LVL_NONE;
		end else if (reading_crit && diff >= cfg.crit_delta) begin
			level = LVL_CRITICAL;
		end else if (!st.crit_only && diff >= cfg.normal_delta
			&& item.battery_level > cfg.low_battery) begin
			level = LVL_NORMAL;
		end else begin
			level = LVL_NONE;
		end
	end

	always_comb begin
		st_next = st;
		res.send = 1'b0;
		res.is_critical = 1'b0;
		case (item.mode)
			MODE_SUB: begin
				st_next.subscribed   = 1'b1;
				st_next.crit_only    = item.critical_only;
				st_next.last_reading = item.reading;
				res.send             = 1'b1;
				res.is_critical      = sub_crit;
			end
			MODE_CANCEL: begin
				st_next.subscribed = 1'b0;
			end
			MODE_TICK: begin
				if (active) begin
					st_next.age = expired ? 16'd0 : age_sat;
					case (level)
						LVL_CRITICAL: begin
							st_next.last_reading = item.reading;
							st_next.cur_max_age  = cfg.crit_max_age;
							res.send             = 1'b1;
							res.is_critical      = 1'b1;
						end
						LVL_NORMAL: begin
							st_next.last_reading = item.reading;
							st_next.cur_max_age  = grown_age;
							res.send             = 1'b1;
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
		res.reported_reading = st_next.last_reading;
		res.max_age          = st_next.cur_max_age;
	end

endmodule

`default_nettype wire

@@ hw/rtl/delta_report_filter_unit.sv @@
// top level of the delta report filter: input stage, decision, result stage
// depends on drf_pkg, drf_cfg_regs, drf_decide and assert_macros.svh
//
// channel   handshake              payload
// in        in_valid / in_ready    mode, reading, battery_level, critical_only
// out       out_valid / out_ready  send, is_critical, reported_reading, max_age
// cfg       cfg_we (no wait)       cfg_index, cfg_wdata
//
// every item gives exactly one result, held first in the input register and then in the result register
// one item per cycle sustained while out_ready stays high; the decision sits between the input and result registers
// subscription state is updated in the same cycle the result register loads
// a stalled result holds the input stage, which in turn drops in_ready
// reset clears the handshake state and loads the register and state reset values
`default_nettype none
`include "assert_macros.svh"

module delta_report_filter_unit import drf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            mode,
	input  wire logic signed [7:0]     reading,
	input  wire logic [6:0]            battery_level,
	input  wire logic                  critical_only,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       send,
	output logic                       is_critical,
	output logic signed [7:0]          reported_reading,
	output logic [15:0]                max_age,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	state_t  st_q;
	state_t  st_next;
	result_t res_next;
	logic    load;

	drf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	drf_decide u_decide (
		.cfg     (cfg),
		.st      (st_q),
		.item    (item_s1),
		.st_next (st_next),
		.res     (res_next)
	);

	// item moves on when the result register is empty or draining
	assign load     = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.mode          <= mode;
			item_s1.reading       <= reading;
			item_s1.battery_level <= battery_level;
			item_s1.critical_only <= critical_only;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.subscribed   <= 1'b0;
			st_q.crit_only    <= 1'b0;
			st_q.last_reading <= RST_LAST_READING;
			st_q.age          <= 16'd0;
			st_q.cur_max_age  <= RST_MAX_AGE_LIMIT;
		end else if (load) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid        = valid_s2;
	assign send             = res_s2.send;
	assign is_critical      = res_s2.is_critical;
	assign reported_reading = $signed(res_s2.reported_reading);
	assign max_age          = res_s2.max_age;

	`DRF_ASSERT_IMPLY(a_ready_when_empty, clk, arst_n, !valid_s1, in_ready)
	`DRF_ASSERT_IMPLY(a_no_overwrite, clk, arst_n, valid_s2 && !out_ready, !load)
	`DRF_ASSERT_NEXT(a_state_holds, clk, arst_n, !load, $stable(st_q))
	`DRF_ASSERT_NEXT(a_send_needs_sub, clk, arst_n, load && res_next.send, st_q.subscribed)

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// self-checking testbench for delta_report_filter_unit: directed and random items with
// shadow-model prediction of every result, random idling on both channels and register changes
// depends on drf_pkg and the rtl of delta_report_filter_unit
`default_nettype none

module tb_top import drf_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int QUIET_LIMIT = 1000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            mode;
	logic signed [7:0]     reading;
	logic [6:0]            battery_level;
	logic                  critical_only;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  send;
	logic                  is_critical;
	logic signed [7:0]     reported_reading;
	logic [15:0]           max_age;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// shadow of the register file and of the subscription state
	cfg_t              live_cfg;
	logic              sub_active;
	logic              conly_wish;
	logic signed [7:0] last_sent_reading;
	int unsigned       age_acc;
	int unsigned       age_ceiling;

	result_t pending_reports[$];
	result_t due_report;
	int      err_count = 0;
	int      items_sent = 0;
	int      tx_idle_pct = 0;
	int      rx_idle_pct = 0;
	int      hold_len = 0;
	int      quiet_cycles = 0;

	delta_report_filter_unit DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.reading          (reading),
		.battery_level    (battery_level),
		.critical_only    (critical_only),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.send             (send),
		.is_critical      (is_critical),
		.reported_reading (reported_reading),
		.max_age          (max_age),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic note_mismatch(input string what);
		err_count++;
		$display("[%0t] report mismatch: %s", $time, what);
	endtask

	task automatic reset_filter_model();
		live_cfg = {RST_CRIT_THRESHOLD, RST_CRIT_DELTA, RST_NORMAL_DELTA, RST_MAX_AGE_LIMIT,
			RST_CRIT_MAX_AGE, RST_TICK_PERIOD, RST_LOW_BATTERY};
		sub_active = 1'b0;
		conly_wish = 1'b0;
		last_sent_reading = RST_LAST_READING;
		age_acc = 0;
		age_ceiling = RST_MAX_AGE_LIMIT;
	endtask

	// works out the one result of an item and advances the shadow state
	task automatic predict_report(input logic [1:0] m, input logic signed [7:0] r,
			input logic [6:0] b, input logic c);
		result_t     exp_r;
		int          thr;
		int          diff;
		int unsigned nxt;
		logic        crit_now;
		level_t      lvl;
		thr = int'($signed(live_cfg.crit_threshold));
		exp_r = '0;
		lvl = LVL_NONE;
		if (m == MODE_SUB) begin
			conly_wish = c;
			sub_active = 1'b1;
			last_sent_reading = r;
			exp_r.send = 1'b1;
			// the answer to a subscribe is critical only strictly above the threshold
			exp_r.is_critical = (int'(r) > thr);
		end else if (m == MODE_CANCEL) begin
			sub_active = 1'b0;
		end else if (m == MODE_TICK && sub_active && b != 0) begin
			age_acc = age_acc + live_cfg.tick_period;
			if (age_acc > AGE_MAX)
				age_acc = AGE_MAX;
			diff = int'(r) - int'(last_sent_reading);
			if (diff < 0)
				diff = -diff;
			crit_now = (int'(r) >= thr);
			// expiry looks one tick period ahead of the advanced age
			if (age_acc + live_cfg.tick_period >= age_ceiling) begin
				age_acc = 0;
				if (crit_now)
					lvl = LVL_CRITICAL;
				else if (!conly_wish)
					lvl = LVL_NORMAL;
			end else if (crit_now && diff >= live_cfg.crit_delta) begin
				lvl = LVL_CRITICAL;
			end else if (!conly_wish && diff >= live_cfg.normal_delta &&
					b > live_cfg.low_battery) begin
				lvl = LVL_NORMAL;
			end
			if (lvl != LVL_NONE) begin
				last_sent_reading = r;
				if (lvl == LVL_CRITICAL) begin
					age_ceiling = live_cfg.crit_max_age;
				end else begin
					nxt = (age_ceiling == live_cfg.crit_max_age) ? AGE_STEP
						: age_ceiling + AGE_STEP;
					if (nxt > live_cfg.max_age_limit)
						nxt = live_cfg.max_age_limit;
					age_ceiling = nxt;
				end
				exp_r.send = 1'b1;
				exp_r.is_critical = (lvl == LVL_CRITICAL);
			end
		end
		exp_r.reported_reading = last_sent_reading;
		exp_r.max_age = age_ceiling[15:0];
		pending_reports.push_back(exp_r);
	endtask

	// one input transfer; valid stays up between back-to-back items
	task automatic push_item(input logic [1:0] item_mode, input logic signed [7:0] item_reading,
			input logic [6:0] item_battery, input logic item_conly);
		while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= item_mode;
		reading       <= item_reading;
		battery_level <= item_battery;
		critical_only <= item_conly;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		predict_report(item_mode, item_reading, item_battery, item_conly);
		if (item_mode != MODE_SPARE)
			items_sent++;
	endtask

	task automatic wait_all_reports();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	task automatic apply_settings(input cfg_t s);
		wait_all_reports();
		reg_write(REG_CRIT_THRESHOLD, {{8{s.crit_threshold[7]}}, s.crit_threshold});
		reg_write(REG_CRIT_DELTA, {8'd0, s.crit_delta});
		reg_write(REG_NORMAL_DELTA, {8'd0, s.normal_delta});
		reg_write(REG_MAX_AGE_LIMIT, s.max_age_limit);
		reg_write(REG_CRIT_MAX_AGE, s.crit_max_age);
		reg_write(REG_TICK_PERIOD, {8'd0, s.tick_period});
		reg_write(REG_LOW_BATTERY, {9'd0, s.low_battery});
		cfg_we <= 1'b0;
		live_cfg = s;
	endtask

	function automatic cfg_t preset_settings(input int k);
		cfg_t s;
		case (k)
			1: s = {8'h80, 8'd0, 8'd0, 16'd1, 16'd1, 8'd1, 7'd0};
			2: s = {8'h7F, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 8'd255, 7'd100};
			3: s = {8'd0, 8'd3, 8'd6, 16'd200, 16'd20, 8'd7, 7'd50};
			4: s = {8'hEC, 8'd2, 8'd10, 16'd100, 16'd30, 8'd30, 7'd60};
			default: s = {RST_CRIT_THRESHOLD, RST_CRIT_DELTA, RST_NORMAL_DELTA,
				RST_MAX_AGE_LIMIT, RST_CRIT_MAX_AGE, RST_TICK_PERIOD, RST_LOW_BATTERY};
		endcase
		return s;
	endfunction

	function automatic cfg_t random_settings();
		cfg_t s;
		s.crit_threshold = 8'($urandom_range(0, 255));
		s.crit_delta     = 8'($urandom_range(0, 8));
		s.normal_delta   = 8'($urandom_range(0, 12));
		s.max_age_limit  = 16'($urandom_range(1, 300));
		s.crit_max_age   = 16'($urandom_range(1, 100));
		s.tick_period    = 8'($urandom_range(1, 40));
		s.low_battery    = 7'($urandom_range(0, 100));
		return s;
	endfunction

	// mostly small steps, some near the threshold, a few anywhere
	function automatic logic signed [7:0] next_reading(input logic signed [7:0] cur);
		int pick;
		int v;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			v = int'($urandom_range(0, 255)) - 128;
		else if (pick < 30)
			v = int'($signed(live_cfg.crit_threshold)) + int'($urandom_range(0, 4)) - 2;
		else
			v = int'(cur) + int'($urandom_range(0, 8)) - 4;
		if (v > 127)
			v = 127;
		if (v < -128)
			v = -128;
		return v[7:0];
	endfunction

	function automatic logic [6:0] pick_battery();
		int pick;
		int v;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			v = 0;
		else if (pick < 13)
			v = $urandom_range(101, 127);
		else if (pick < 35)
			v = live_cfg.low_battery + $urandom_range(0, 2);
		else
			v = $urandom_range(1, 100);
		return v[6:0];
	endfunction

	// subscribe, a run of ticks with some noise mixed in, maybe a cancel
	task automatic run_session();
		int                ticks;
		int                noise;
		logic signed [7:0] rd;
		rd = next_reading($signed(live_cfg.crit_threshold));
		push_item(MODE_SUB, rd, pick_battery(), $urandom_range(0, 3) == 0);
		ticks = $urandom_range(4, 40);
		repeat (ticks) begin
			noise = $urandom_range(0, 99);
			if (noise < 4) begin
				push_item(MODE_SPARE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
					1'($urandom_range(0, 1)));
			end else if (noise < 7) begin
				push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
			end else begin
				rd = next_reading(rd);
				push_item(MODE_TICK, rd, pick_battery(), 1'($urandom_range(0, 1)));
			end
		end
		if ($urandom_range(0, 1) == 1)
			push_item(MODE_CANCEL, 8'($urandom_range(0, 255)), pick_battery(),
				1'($urandom_range(0, 1)));
	endtask

	// runs with the reset register values
	task automatic test_directed_cases();
		push_item(MODE_TICK, 0, 50, 1'b0);       // tick before any subscribe
		push_item(MODE_SPARE, -1, 127, 1'b1);    // unused mode
		push_item(MODE_CANCEL, 5, 10, 1'b1);
		push_item(MODE_SUB, 35, 100, 1'b0);      // at threshold, not above
		push_item(MODE_SUB, 36, 100, 1'b0);
		push_item(MODE_TICK, 100, 0, 1'b0);      // empty battery
		push_item(MODE_TICK, 36, 30, 1'b0);
		push_item(MODE_TICK, 38, 30, 1'b0);      // critical change
		push_item(MODE_TICK, 20, 31, 1'b0);      // expiry from the short max age
		push_item(MODE_TICK, 22, 30, 1'b0);
		push_item(MODE_TICK, 23, 100, 1'b0);
		push_item(MODE_TICK, 25, 30, 1'b0);      // battery at the limit
		push_item(MODE_TICK, -128, 31, 1'b0);
		push_item(MODE_TICK, 127, 64, 1'b0);
		push_item(MODE_SUB, -128, 1, 1'b1);      // critical-only subscriber
		push_item(MODE_TICK, 10, 100, 1'b0);
		push_item(MODE_TICK, 35, 100, 1'b0);
		push_item(MODE_TICK, 34, 100, 1'b0);
		push_item(MODE_CANCEL, 0, 50, 1'b0);
		push_item(MODE_SUB, 0, 100, 1'b0);
		// normal reports walk the max age up to the limit
		for (int k = 0; k < 7; k++)
			push_item(MODE_TICK, 8'((k % 2 == 0) ? 20 : 0), 100, 1'b0);
	endtask

	task automatic test_random_traffic(input int phase, input int tx_pct, input int rx_pct);
		int   stop_at;
		cfg_t s;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int j = 0; j < 4; j++) begin
			s = (j == 3) ? random_settings() : preset_settings((phase * 3 + j) % 5);
			apply_settings(s);
			stop_at = items_sent + 120;
			while (items_sent < stop_at)
				run_session();
		end
	endtask

	// result side blocked long enough to back up the input, then a full drain
	task automatic test_output_stall();
		logic signed [7:0] rd;
		wait_all_reports();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_len = 80;
		rd = next_reading($signed(live_cfg.crit_threshold));
		push_item(MODE_SUB, rd, 7'd90, 1'b0);
		repeat (29) begin
			rd = next_reading(rd);
			push_item(MODE_TICK, rd, pick_battery(), 1'b0);
		end
		wait_all_reports();
	endtask

	always @(posedge clk) begin
		if (hold_len > 0) begin
			out_ready <= 1'b0;
			hold_len--;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_reports.size() == 0) begin
				note_mismatch("result transfer with no prediction waiting");
			end else begin
				due_report = pending_reports.pop_front();
				if (send !== due_report.send)
					note_mismatch($sformatf("send %b, predicted %b", send, due_report.send));
				if (is_critical !== due_report.is_critical)
					note_mismatch($sformatf("is_critical %b, predicted %b", is_critical,
						due_report.is_critical));
				if (reported_reading !== due_report.reported_reading)
					note_mismatch($sformatf("reported_reading %0d, predicted %0d",
						reported_reading, $signed(due_report.reported_reading)));
				if (max_age !== due_report.max_age)
					note_mismatch($sformatf("max_age %0d, predicted %0d", max_age,
						due_report.max_age));
			end
		end
	end

	// ends the run when neither channel has moved for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		mode          <= MODE_TICK;
		reading       <= '0;
		battery_level <= '0;
		critical_only <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_CRIT_THRESHOLD;
		cfg_wdata     <= '0;
		reset_filter_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_traffic(0, 18, 85);
		test_random_traffic(1, 85, 18);
		test_random_traffic(2, 0, 0);
		test_output_stall();

		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/drf_pkg.sv
hw/rtl/drf_cfg_regs.sv
hw/rtl/drf_decide.sv
hw/rtl/delta_report_filter_unit.sv
dv/tb_top.sv
